/* rtl/llcp_pkg.sv */
`timescale 1ns / 1ps
// Shared widths, constants and transaction types for the line-line closest points block.
package llcp_pkg;

    // Coordinate width of every input field (signed, 8 fraction bits).
    localparam int LLCP_COORD_BITS = 16;

    // Derived widths of the internal arithmetic.
    localparam int LLCP_CW    = LLCP_COORD_BITS;
    localparam int LLCP_UW    = LLCP_CW + 1;
    localparam int LLCP_KW    = 2 * LLCP_CW + 3;
    localparam int LLCP_DW    = 2 * LLCP_KW + 1;
    localparam int LLCP_FRAC  = 16;
    localparam int LLCP_NW    = LLCP_DW + LLCP_FRAC;
    localparam int LLCP_PW    = 32;
    localparam int LLCP_RW    = LLCP_DW + LLCP_PW + 1;
    localparam int LLCP_GW    = LLCP_KW + LLCP_PW + 2;
    localparam int LLCP_ACW   = LLCP_KW + 2 * LLCP_PW + 4;
    localparam int LLCP_DISTW = 48;

    // Divider latency: operand register, one stage per quotient bit, result register.
    localparam int LLCP_DIV_LAT = LLCP_PW + 2;

    // Default depth of the queue between front and back.
    localparam int LLCP_QUEUE_DEPTH = 4;

    localparam logic signed [LLCP_PW-1:0] LLCP_PARAM_MAX = {1'b0, {(LLCP_PW-1){1'b1}}};
    localparam logic signed [LLCP_PW-1:0] LLCP_PARAM_MIN = {1'b1, {(LLCP_PW-1){1'b0}}};
    localparam logic [LLCP_DISTW-1:0]     LLCP_DIST_MAX  = {LLCP_DISTW{1'b1}};

    typedef enum logic [1:0] {
        LLCP_ST_GENERAL  = 2'd0,
        LLCP_ST_PARALLEL = 2'd1,
        LLCP_ST_ZERO_DIR = 2'd2
    } t_status;

    typedef struct packed {
        logic signed [LLCP_CW-1:0] point1_x;
        logic signed [LLCP_CW-1:0] point1_y;
        logic signed [LLCP_CW-1:0] point1_z;
        logic signed [LLCP_CW-1:0] dir1_x;
        logic signed [LLCP_CW-1:0] dir1_y;
        logic signed [LLCP_CW-1:0] dir1_z;
        logic signed [LLCP_CW-1:0] point2_x;
        logic signed [LLCP_CW-1:0] point2_y;
        logic signed [LLCP_CW-1:0] point2_z;
        logic signed [LLCP_CW-1:0] dir2_x;
        logic signed [LLCP_CW-1:0] dir2_y;
        logic signed [LLCP_CW-1:0] dir2_z;
    } t_in;

    typedef struct packed {
        logic signed [LLCP_PW-1:0] param_first;
        logic signed [LLCP_PW-1:0] param_second;
        logic [LLCP_DISTW-1:0]     dist_squared;
        logic [1:0]                status;
    } t_out;

    // Dot products of one item, with the zero first direction flag.
    typedef struct packed {
        logic signed [LLCP_KW-1:0] a;
        logic signed [LLCP_KW-1:0] b;
        logic signed [LLCP_KW-1:0] c;
        logic signed [LLCP_KW-1:0] d;
        logic signed [LLCP_KW-1:0] e;
        logic signed [LLCP_KW-1:0] f;
        logic                      zero;
    } t_coef;

    typedef struct packed {
        t_coef   coef;
        t_status status;
    } t_side;

    typedef struct packed {
        t_side                     side;
        logic signed [LLCP_PW-1:0] s;
        logic signed [LLCP_PW-1:0] t;
    } t_post;

endpackage

/* rtl/llcp_mul.sv */
`timescale 1ns / 1ps
// Two-stage signed multiplier built from four registered partial products.
module llcp_mul #(
    parameter int AW = llcp_pkg::LLCP_KW,
    parameter int BW = llcp_pkg::LLCP_KW
) (
    input  logic                     i_clk,
    input  logic                     i_en,
    input  logic signed [AW-1:0]     i_a,
    input  logic signed [BW-1:0]     i_b,
    output logic signed [AW+BW-1:0]  o_p
);
    localparam int HA = AW / 2;
    localparam int HB = BW / 2;
    localparam int LA = AW - HA;
    localparam int LB = BW - HB;
    localparam int PW = AW + BW;

    logic signed [HA:0]           w_a_lo;
    logic signed [LA-1:0]         w_a_hi;
    logic signed [HB:0]           w_b_lo;
    logic signed [LB-1:0]         w_b_hi;
    logic signed [HA+HB+1:0]      r_ll;
    logic signed [LA+HB:0]        r_hl;
    logic signed [HA+LB:0]        r_lh;
    logic signed [LA+LB-1:0]      r_hh;
    logic signed [PW-1:0]         n_p;

    // Split each operand into an unsigned low half and a signed high half.
    assign w_a_lo = {1'b0, i_a[HA-1:0]};
    assign w_a_hi = i_a[AW-1:HA];
    assign w_b_lo = {1'b0, i_b[HB-1:0]};
    assign w_b_hi = i_b[BW-1:HB];

    // First stage: the partial products.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_ll <= w_a_lo * w_b_lo;
            r_hl <= w_a_hi * w_b_lo;
            r_lh <= w_a_lo * w_b_hi;
            r_hh <= w_a_hi * w_b_hi;
        end
    end

    // Second stage: align and add the partial products.
    always_comb begin
        n_p = (PW'(r_hh) <<< (HA + HB)) + (PW'(r_hl) <<< HA) + (PW'(r_lh) <<< HB)
            + PW'(r_ll);
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_p <= n_p;
        end
    end

endmodule

/* rtl/llcp_div.sv */
`timescale 1ns / 1ps
// Pipelined restoring divider, one quotient bit per stage, with saturation to Q15.16.
module llcp_div (
    input  logic                               i_clk,
    input  logic                               i_en,
    input  logic [llcp_pkg::LLCP_NW-1:0]       i_num,
    input  logic [llcp_pkg::LLCP_DW-1:0]       i_den,
    input  logic                               i_neg,
    output logic signed [llcp_pkg::LLCP_PW-1:0] o_q
);
    localparam int RW = llcp_pkg::LLCP_RW;
    localparam int DW = llcp_pkg::LLCP_DW;
    localparam int QW = llcp_pkg::LLCP_PW;

    logic [RW-1:0] r_rem [0:QW];
    logic [DW-1:0] r_den [0:QW];
    logic [QW-1:0] r_q   [0:QW];
    logic          r_neg [0:QW];
    logic          r_ovf [0:QW];
    logic          w_ovf;
    logic [QW-1:0] w_mag;
    logic signed [QW-1:0] n_q;

    // A quotient of 2^32 or more saturates in any case.
    assign w_ovf = RW'(i_num) >= (RW'(i_den) << QW);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem[0] <= RW'(i_num);
            r_den[0] <= i_den;
            r_q[0]   <= '0;
            r_neg[0] <= i_neg;
            r_ovf[0] <= w_ovf;
        end
    end

    // Each stage settles one quotient bit, most significant first.
    for (genvar gi = 0; gi < QW; gi++) begin : g_stage
        localparam int BIT = QW - 1 - gi;
        logic [RW-1:0] w_shift;
        logic          w_ge;

        assign w_shift = RW'(r_den[gi]) << BIT;
        assign w_ge    = r_rem[gi] >= w_shift;

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[gi+1] <= w_ge ? (r_rem[gi] - w_shift) : r_rem[gi];
                r_den[gi+1] <= r_den[gi];
                r_q[gi+1]   <= {r_q[gi][QW-2:0], w_ge};
                r_neg[gi+1] <= r_neg[gi];
                r_ovf[gi+1] <= r_ovf[gi];
            end
        end
    end

    // Apply the sign and saturate to the signed 32-bit range.
    assign w_mag = r_q[QW];

    always_comb begin
        if (r_neg[QW]) begin
            if (r_ovf[QW] || (w_mag > {1'b1, {(QW-1){1'b0}}})) begin
                n_q = llcp_pkg::LLCP_PARAM_MIN;
            end else begin
                n_q = -$signed(w_mag);
            end
        end else begin
            if (r_ovf[QW] || w_mag[QW-1]) begin
                n_q = llcp_pkg::LLCP_PARAM_MAX;
            end else begin
                n_q = $signed(w_mag);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_q <= n_q;
        end
    end

endmodule

/* rtl/llcp_front.sv */
`timescale 1ns / 1ps
// Front part: takes input transactions and forms the six dot products and the zero flag.
module llcp_front (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_stall,
    input  llcp_pkg::t_in        i_data,
    input  logic                 i_full,
    output logic                 o_push,
    output llcp_pkg::t_coef      o_coef
);
    localparam int CW = llcp_pkg::LLCP_CW;
    localparam int UW = llcp_pkg::LLCP_UW;
    localparam int KW = llcp_pkg::LLCP_KW;

    logic                  w_en;
    llcp_pkg::t_in         r_in;
    logic                  r_in_v;
    logic signed [UW-1:0]  r_u  [0:2];
    logic signed [CW-1:0]  r_d1 [0:2];
    logic signed [CW-1:0]  r_d2 [0:2];
    logic                  r_u_v;
    logic signed [UW-1:0]  n_u  [0:2];
    logic signed [2*CW-1:0]   w_p11 [0:2];
    logic signed [2*CW-1:0]   w_p12 [0:2];
    logic signed [2*CW-1:0]   w_p22 [0:2];
    logic signed [CW+UW-1:0]  w_p1u [0:2];
    logic signed [CW+UW-1:0]  w_p2u [0:2];
    logic signed [2*UW-1:0]   w_puu [0:2];
    llcp_pkg::t_coef       n_coef;
    llcp_pkg::t_coef       r_coef;
    logic                  r_coef_v;

    // The whole front holds while its last stage waits on a full queue.
    assign w_en    = !(r_coef_v && i_full);
    assign o_stall = !w_en;
    assign o_push  = r_coef_v && !i_full;
    assign o_coef  = r_coef;

    // Difference of the two line points.
    always_comb begin
        n_u[0] = UW'(r_in.point1_x) - UW'(r_in.point2_x);
        n_u[1] = UW'(r_in.point1_y) - UW'(r_in.point2_y);
        n_u[2] = UW'(r_in.point1_z) - UW'(r_in.point2_z);
    end

    // Per-axis products.
    always_comb begin
        for (int k = 0; k < 3; k++) begin
            w_p11[k] = r_d1[k] * r_d1[k];
            w_p12[k] = r_d1[k] * r_d2[k];
            w_p22[k] = r_d2[k] * r_d2[k];
            w_p1u[k] = r_d1[k] * r_u[k];
            w_p2u[k] = r_d2[k] * r_u[k];
            w_puu[k] = r_u[k] * r_u[k];
        end
    end

    // Sum over the three axes.
    always_comb begin
        n_coef.a = KW'(w_p11[0]) + KW'(w_p11[1]) + KW'(w_p11[2]);
        n_coef.b = -(KW'(w_p12[0]) + KW'(w_p12[1]) + KW'(w_p12[2]));
        n_coef.c = KW'(w_p22[0]) + KW'(w_p22[1]) + KW'(w_p22[2]);
        n_coef.d = KW'(w_p1u[0]) + KW'(w_p1u[1]) + KW'(w_p1u[2]);
        n_coef.e = -(KW'(w_p2u[0]) + KW'(w_p2u[1]) + KW'(w_p2u[2]));
        n_coef.f = KW'(w_puu[0]) + KW'(w_puu[1]) + KW'(w_puu[2]);
        n_coef.zero = (n_coef.a == '0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_v   <= 1'b0;
            r_u_v    <= 1'b0;
            r_coef_v <= 1'b0;
        end else if (w_en) begin
            r_in_v   <= i_valid;
            r_in     <= i_data;
            r_u_v    <= r_in_v;
            r_u      <= n_u;
            r_d1[0]  <= r_in.dir1_x;
            r_d1[1]  <= r_in.dir1_y;
            r_d1[2]  <= r_in.dir1_z;
            r_d2[0]  <= r_in.dir2_x;
            r_d2[1]  <= r_in.dir2_y;
            r_d2[2]  <= r_in.dir2_z;
            r_coef_v <= r_u_v;
            r_coef   <= n_coef;
        end
    end

endmodule

/* rtl/llcp_queue.sv */
`timescale 1ns / 1ps
// Short queue of dot-product sets between the front and back parts.
module llcp_queue #(
    parameter int DEPTH = llcp_pkg::LLCP_QUEUE_DEPTH
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  llcp_pkg::t_coef i_data,
    input  logic            i_pop,
    output llcp_pkg::t_coef o_data,
    output logic            o_full,
    output logic            o_avail
);
    localparam int AW = $clog2(DEPTH);
    localparam int CNTW = $clog2(DEPTH + 1);

    llcp_pkg::t_coef r_mem [0:DEPTH-1];
    logic [AW-1:0]   r_wr;
    logic [AW-1:0]   r_rd;
    logic [CNTW-1:0] r_cnt;
    logic [AW-1:0]   n_wr;
    logic [AW-1:0]   n_rd;

    assign o_full  = (r_cnt == CNTW'(DEPTH));
    assign o_avail = (r_cnt != '0);
    assign o_data  = r_mem[r_rd];

    // Pointers wrap at the queue depth.
    assign n_wr = (r_wr == AW'(DEPTH - 1)) ? '0 : (r_wr + AW'(1));
    assign n_rd = (r_rd == AW'(DEPTH - 1)) ? '0 : (r_rd + AW'(1));

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= n_wr;
            end
            if (i_pop) begin
                r_rd <= n_rd;
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + CNTW'(1);
            end else if (!i_push && i_pop) begin
                r_cnt <= r_cnt - CNTW'(1);
            end
        end
    end

    // The front never writes a full queue and the back never reads an empty one.
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_full |-> !i_push)
        else $error("queue written while full");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> o_avail)
        else $error("queue read while empty");

endmodule

/* rtl/llcp_back.sv */
`timescale 1ns / 1ps
// Back part: determinant, two pipelined divisions and the squared distance.
module llcp_back (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_avail,
    input  llcp_pkg::t_coef i_coef,
    output logic            o_pop,
    output logic            o_valid,
    input  logic            i_stall,
    output llcp_pkg::t_out  o_data
);
    localparam int KW   = llcp_pkg::LLCP_KW;
    localparam int DW   = llcp_pkg::LLCP_DW;
    localparam int NW   = llcp_pkg::LLCP_NW;
    localparam int PW   = llcp_pkg::LLCP_PW;
    localparam int GW   = llcp_pkg::LLCP_GW;
    localparam int ACW  = llcp_pkg::LLCP_ACW;
    localparam int FR   = llcp_pkg::LLCP_FRAC;
    localparam int DSW  = llcp_pkg::LLCP_DISTW;
    localparam int LAT  = llcp_pkg::LLCP_DIV_LAT;
    localparam int SHW  = ACW - 2 * FR;

    logic w_en;

    // Entry stage.
    llcp_pkg::t_coef r_b0;
    logic            r_b0_v;

    // Determinant and numerator products.
    logic signed [2*KW-1:0] w_ac, w_bb, w_be, w_cd, w_bd, w_ae;
    llcp_pkg::t_coef r_mc [0:1];
    logic            r_mc_v [0:1];

    // Determinant magnitude and numerators.
    logic signed [DW-1:0] n_det_raw;
    logic [DW-1:0]        n_det;
    logic [DW-1:0]        r_b3_det;
    logic signed [DW-1:0] r_b3_ns;
    logic signed [DW-1:0] r_b3_nt;
    llcp_pkg::t_coef      r_b3_c;
    logic                 r_b3_v;

    // Divider operands.
    logic                 w_par;
    llcp_pkg::t_side      n_side;
    logic [DW-1:0]        w_abs_ns;
    logic [DW-1:0]        w_abs_nt;
    logic [KW-1:0]        w_abs_d;
    logic [NW-1:0]        r_b4_num_s;
    logic [NW-1:0]        r_b4_num_t;
    logic [DW-1:0]        r_b4_den_s;
    logic [DW-1:0]        r_b4_den_t;
    logic                 r_b4_neg_s;
    logic                 r_b4_neg_t;
    llcp_pkg::t_side      r_b4_side;
    logic                 r_b4_v;

    // Division results and the matching side line.
    logic signed [PW-1:0] w_s;
    logic signed [PW-1:0] w_t;
    llcp_pkg::t_side      r_dl_side [0:LAT-1];
    logic                 r_dl_v    [0:LAT-1];

    // Parameters after the special cases.
    llcp_pkg::t_post      n_b5;
    llcp_pkg::t_post      r_b5;
    logic                 r_b5_v;

    // First distance products.
    logic signed [KW+PW-1:0] w_as, w_bt, w_bs, w_ct, w_ds;
    llcp_pkg::t_post      r_m1 [0:1];
    logic                 r_m1_v [0:1];

    // Gradient terms.
    logic signed [GW-1:0]    r_b6_g1;
    logic signed [GW-1:0]    r_b6_g2;
    logic signed [KW+PW-1:0] r_b6_ds;
    llcp_pkg::t_post         r_b6;
    logic                    r_b6_v;

    // Second distance products.
    logic signed [GW+PW-1:0] w_sg1, w_tg2;
    llcp_pkg::t_post         r_m2 [0:1];
    logic signed [KW+PW-1:0] r_m2_ds [0:1];
    logic                    r_m2_v [0:1];

    // Accumulated distance and the result register.
    logic signed [ACW-1:0] n_acc;
    logic signed [ACW-1:0] r_b7_acc;
    llcp_pkg::t_post       r_b7;
    logic                  r_b7_v;
    logic [ACW-1:0]        w_mag;
    logic [SHW-1:0]        w_shr;
    llcp_pkg::t_out        n_out;
    llcp_pkg::t_out        r_out;
    logic                  r_out_v;

    // The pipeline advances unless a finished result is held.
    assign w_en    = !(r_out_v && i_stall);
    assign o_pop   = i_avail && w_en;
    assign o_valid = r_out_v;
    assign o_data  = r_out;

    llcp_mul #(.AW(KW), .BW(KW)) u_mul_ac (
        .i_clk(i_clk), .i_en(w_en), .i_a(r_b0.a), .i_b(r_b0.c), .o_p(w_ac));
    llcp_mul #(.AW(KW), .BW(KW)) u_mul_bb (
        .i_clk(i_clk), .i_en(w_en), .i_a(r_b0.b), .i_b(r_b0.b), .o_p(w_bb));
    llcp_mul #(.AW(KW), .BW(KW)) u_mul_be (
        .i_clk(i_clk), .i_en(w_en), .i_a(r_b0.b), .i_b(r_b0.e), .o_p(w_be));
    llcp_mul #(.AW(KW), .BW(KW)) u_mul_cd (
        .i_clk(i_clk), .i_en(w_en), .i_a(r_b0.c), .i_b(r_b0.d), .o_p(w_cd));
    llcp_mul #(.AW(KW), .BW(KW)) u_mul_bd (
        .i_clk(i_clk), .i_en(w_en), .i_a(r_b0.b), .i_b(r_b0.d), .o_p(w_bd));
    llcp_mul #(.AW(KW), .BW(KW)) u_mul_ae (
        .i_clk(i_clk), .i_en(w_en), .i_a(r_b0.a), .i_b(r_b0.e), .o_p(w_ae));

    // Determinant magnitude; the two numerators are formed in the payload registers.
    always_comb begin
        n_det_raw = DW'(w_ac) - DW'(w_bb);
        n_det     = n_det_raw[DW-1] ? DW'(-n_det_raw) : DW'(n_det_raw);
    end

    // Classify the item and pick the divider operands.
    always_comb begin
        w_par    = (r_b3_det == '0);
        w_abs_ns = r_b3_ns[DW-1] ? DW'(-r_b3_ns) : DW'(r_b3_ns);
        w_abs_nt = r_b3_nt[DW-1] ? DW'(-r_b3_nt) : DW'(r_b3_nt);
        w_abs_d  = r_b3_c.d[KW-1] ? KW'(-r_b3_c.d) : KW'(r_b3_c.d);
        n_side.coef = r_b3_c;
        if (r_b3_c.zero) begin
            n_side.status = llcp_pkg::LLCP_ST_ZERO_DIR;
        end else if (w_par) begin
            n_side.status = llcp_pkg::LLCP_ST_PARALLEL;
        end else begin
            n_side.status = llcp_pkg::LLCP_ST_GENERAL;
        end
    end

    llcp_div u_div_s (
        .i_clk(i_clk), .i_en(w_en), .i_num(r_b4_num_s), .i_den(r_b4_den_s),
        .i_neg(r_b4_neg_s), .o_q(w_s));
    llcp_div u_div_t (
        .i_clk(i_clk), .i_en(w_en), .i_num(r_b4_num_t), .i_den(r_b4_den_t),
        .i_neg(r_b4_neg_t), .o_q(w_t));

    // Special cases force the parameters.
    always_comb begin
        n_b5.side = r_dl_side[LAT-1];
        n_b5.s    = w_s;
        n_b5.t    = w_t;
        if (r_dl_side[LAT-1].status == llcp_pkg::LLCP_ST_ZERO_DIR) begin
            n_b5.s = '0;
            n_b5.t = '0;
        end else if (r_dl_side[LAT-1].status == llcp_pkg::LLCP_ST_PARALLEL) begin
            n_b5.t = '0;
        end
    end

    llcp_mul #(.AW(KW), .BW(PW)) u_mul_as (
        .i_clk(i_clk), .i_en(w_en), .i_a(r_b5.side.coef.a), .i_b(r_b5.s), .o_p(w_as));
    llcp_mul #(.AW(KW), .BW(PW)) u_mul_bt (
        .i_clk(i_clk), .i_en(w_en), .i_a(r_b5.side.coef.b), .i_b(r_b5.t), .o_p(w_bt));
    llcp_mul #(.AW(KW), .BW(PW)) u_mul_bs (
        .i_clk(i_clk), .i_en(w_en), .i_a(r_b5.side.coef.b), .i_b(r_b5.s), .o_p(w_bs));
    llcp_mul #(.AW(KW), .BW(PW)) u_mul_ct (
        .i_clk(i_clk), .i_en(w_en), .i_a(r_b5.side.coef.c), .i_b(r_b5.t), .o_p(w_ct));
    llcp_mul #(.AW(KW), .BW(PW)) u_mul_ds (
        .i_clk(i_clk), .i_en(w_en), .i_a(r_b5.side.coef.d), .i_b(r_b5.s), .o_p(w_ds));

    llcp_mul #(.AW(GW), .BW(PW)) u_mul_sg1 (
        .i_clk(i_clk), .i_en(w_en), .i_a(r_b6_g1), .i_b(r_b6.s), .o_p(w_sg1));
    llcp_mul #(.AW(GW), .BW(PW)) u_mul_tg2 (
        .i_clk(i_clk), .i_en(w_en), .i_a(r_b6_g2), .i_b(r_b6.t), .o_p(w_tg2));

    // Quadratic form for general lines; the parallel form keeps the same scale.
    always_comb begin
        if (r_m2[1].side.status == llcp_pkg::LLCP_ST_PARALLEL) begin
            n_acc = (ACW'(r_m2_ds[1]) <<< FR) + (ACW'(r_m2[1].side.coef.f) <<< (2 * FR));
        end else begin
            n_acc = ACW'(w_sg1) + ACW'(w_tg2) + (ACW'(r_m2[1].side.coef.f) <<< (2 * FR));
        end
    end

    // Magnitude, drop the fraction bits, saturate.
    always_comb begin
        w_mag = r_b7_acc[ACW-1] ? ACW'(-r_b7_acc) : ACW'(r_b7_acc);
        w_shr = w_mag[ACW-1:2*FR];
        n_out.param_first  = r_b7.s;
        n_out.param_second = r_b7.t;
        n_out.status       = r_b7.side.status;
        if ((r_b7.side.status == llcp_pkg::LLCP_ST_ZERO_DIR) || (|w_shr[SHW-1:DSW])) begin
            n_out.dist_squared = llcp_pkg::LLCP_DIST_MAX;
        end else begin
            n_out.dist_squared = w_shr[DSW-1:0];
        end
    end

    // Valid bits of every stage.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b0_v    <= 1'b0;
            r_mc_v[0] <= 1'b0;
            r_mc_v[1] <= 1'b0;
            r_b3_v    <= 1'b0;
            r_b4_v    <= 1'b0;
            for (int k = 0; k < LAT; k++) begin
                r_dl_v[k] <= 1'b0;
            end
            r_b5_v    <= 1'b0;
            r_m1_v[0] <= 1'b0;
            r_m1_v[1] <= 1'b0;
            r_b6_v    <= 1'b0;
            r_m2_v[0] <= 1'b0;
            r_m2_v[1] <= 1'b0;
            r_b7_v    <= 1'b0;
            r_out_v   <= 1'b0;
        end else if (w_en) begin
            r_b0_v    <= i_avail;
            r_mc_v[0] <= r_b0_v;
            r_mc_v[1] <= r_mc_v[0];
            r_b3_v    <= r_mc_v[1];
            r_b4_v    <= r_b3_v;
            r_dl_v[0] <= r_b4_v;
            for (int k = 1; k < LAT; k++) begin
                r_dl_v[k] <= r_dl_v[k-1];
            end
            r_b5_v    <= r_dl_v[LAT-1];
            r_m1_v[0] <= r_b5_v;
            r_m1_v[1] <= r_m1_v[0];
            r_b6_v    <= r_m1_v[1];
            r_m2_v[0] <= r_b6_v;
            r_m2_v[1] <= r_m2_v[0];
            r_b7_v    <= r_m2_v[1];
            r_out_v   <= r_b7_v;
        end
    end

    // Payload of every stage.
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_b0     <= i_coef;
            r_mc[0]  <= r_b0;
            r_mc[1]  <= r_mc[0];
            r_b3_det <= n_det;
            r_b3_ns  <= DW'(w_be) - DW'(w_cd);
            r_b3_nt  <= DW'(w_bd) - DW'(w_ae);
            r_b3_c   <= r_mc[1];
            if (w_par) begin
                r_b4_num_s <= NW'(w_abs_d) << FR;
                r_b4_den_s <= DW'($unsigned(r_b3_c.a));
                r_b4_neg_s <= (r_b3_c.d > 0);
            end else begin
                r_b4_num_s <= NW'(w_abs_ns) << FR;
                r_b4_den_s <= r_b3_det;
                r_b4_neg_s <= r_b3_ns[DW-1];
            end
            r_b4_num_t <= NW'(w_abs_nt) << FR;
            r_b4_den_t <= r_b3_det;
            r_b4_neg_t <= r_b3_nt[DW-1];
            r_b4_side  <= n_side;
            r_dl_side[0] <= r_b4_side;
            for (int k = 1; k < LAT; k++) begin
                r_dl_side[k] <= r_dl_side[k-1];
            end
            r_b5     <= n_b5;
            r_m1[0]  <= r_b5;
            r_m1[1]  <= r_m1[0];
            r_b6_g1  <= GW'(w_as) + GW'(w_bt) + (GW'(r_m1[1].side.coef.d) <<< (FR + 1));
            r_b6_g2  <= GW'(w_bs) + GW'(w_ct) + (GW'(r_m1[1].side.coef.e) <<< (FR + 1));
            r_b6_ds  <= w_ds;
            r_b6     <= r_m1[1];
            r_m2[0]  <= r_b6;
            r_m2[1]  <= r_m2[0];
            r_m2_ds[0] <= r_b6_ds;
            r_m2_ds[1] <= r_m2_ds[0];
            r_b7_acc <= n_acc;
            r_b7     <= r_m2[1];
            r_out    <= n_out;
        end
    end

    // A zero first direction gives zero parameters and the saturated distance.
    a_zero_dir: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_v && (r_out.status == llcp_pkg::LLCP_ST_ZERO_DIR)) |->
        ((r_out.dist_squared == llcp_pkg::LLCP_DIST_MAX) && (r_out.param_first == '0)
         && (r_out.param_second == '0)))
        else $error("zero direction result not forced");

    // Parallel lines always report a zero second parameter.
    a_parallel: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_v && (r_out.status == llcp_pkg::LLCP_ST_PARALLEL)) |->
        (r_out.param_second == '0))
        else $error("parallel result has nonzero second parameter");

endmodule

/* rtl/line_line_closest_points_top.sv */
`timescale 1ns / 1ps
// Top level of the closest points between two 3D lines block.
//
//  channel | valid   | stall   | payload
//  --------+---------+---------+-----------------------------
//  input   | i_valid | o_stall | i_data (llcp_pkg::t_in)
//  output  | o_valid | i_stall | o_data (llcp_pkg::t_out)
//
// One transaction is accepted per cycle while o_stall is low; most of the time to its
// result is spent in the two dividers, which settle one quotient bit per stage.
// Reset is synchronous and active low; it clears valid bits, queue pointers and the queue count only.
// A held result stalls the back pipeline; the front keeps accepting until the
// queue between them fills, then raises o_stall.
module line_line_closest_points_top #(
    parameter int QUEUE_DEPTH = llcp_pkg::LLCP_QUEUE_DEPTH
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_stall,
    input  llcp_pkg::t_in  i_data,
    output logic           o_valid,
    input  logic           i_stall,
    output llcp_pkg::t_out o_data
);
    logic            w_push;
    logic            w_pop;
    logic            w_full;
    logic            w_avail;
    llcp_pkg::t_coef w_front_coef;
    llcp_pkg::t_coef w_back_coef;

    llcp_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_data  (i_data),
        .i_full  (w_full),
        .o_push  (w_push),
        .o_coef  (w_front_coef)
    );

    llcp_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_data  (w_front_coef),
        .i_pop   (w_pop),
        .o_data  (w_back_coef),
        .o_full  (w_full),
        .o_avail (w_avail)
    );

    llcp_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_avail (w_avail),
        .i_coef  (w_back_coef),
        .o_pop   (w_pop),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_data  (o_data)
    );

endmodule

/* tb/sv/tb_top.sv */
`timescale 1ns / 1ps
// Self-checking testbench for the line-line closest points block: directed and random streams.
module tb_top;

    localparam int WIDE = 160;
    localparam int IDLE_LIMIT = 5000;
    localparam int DRAIN_CYCLES = 120;

    typedef logic signed [WIDE-1:0] t_wide;

    logic            i_clk = 1'b0;
    logic            i_rst_n = 1'b0;
    logic            i_valid = 1'b0;
    logic            o_stall;
    llcp_pkg::t_in   i_data = '0;
    logic            o_valid;
    logic            i_stall = 1'b0;
    llcp_pkg::t_out  o_data;

    llcp_pkg::t_in   pending_lines[$];
    llcp_pkg::t_out  expected_points[$];
    int    error_count = 0;
    int    idle_cycles = 0;
    bit    input_taken = 1'b0;
    int    burst_left = 0;
    int    gap_left = 0;
    int    stall_mode = 0;
    int    stall_phase_left = 0;

    line_line_closest_points_top u_dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_valid(i_valid),
        .o_stall(o_stall),
        .i_data (i_data),
        .o_valid(o_valid),
        .i_stall(i_stall),
        .o_data (o_data)
    );

    initial begin
        forever #2 i_clk = ~i_clk;
    end

    // Clamp a quotient to the signed Q15.16 range.
    function automatic logic signed [llcp_pkg::LLCP_PW-1:0] clamp_param(t_wide q);
        t_wide pmax;
        t_wide pmin;
        pmax = llcp_pkg::LLCP_PARAM_MAX;
        pmin = llcp_pkg::LLCP_PARAM_MIN;
        if (q > pmax) return llcp_pkg::LLCP_PARAM_MAX;
        if (q < pmin) return llcp_pkg::LLCP_PARAM_MIN;
        return q[llcp_pkg::LLCP_PW-1:0];
    endfunction

    // Absolute value, drop fraction bits, saturate to the distance width.
    function automatic logic [llcp_pkg::LLCP_DISTW-1:0] clamp_dist(t_wide acc, int drop);
        t_wide mag;
        t_wide dmax;
        mag = (acc < 0) ? -acc : acc;
        mag = mag >>> drop;
        dmax = {{(WIDE-llcp_pkg::LLCP_DISTW){1'b0}}, llcp_pkg::LLCP_DIST_MAX};
        if (mag > dmax) return llcp_pkg::LLCP_DIST_MAX;
        return mag[llcp_pkg::LLCP_DISTW-1:0];
    endfunction

    // Closest-point parameters and squared distance for one pair of lines.
    function automatic llcp_pkg::t_out closest_points(llcp_pkg::t_in x);
        t_wide p1[3];
        t_wide d1[3];
        t_wide p2[3];
        t_wide d2[3];
        t_wide u;
        t_wide a, b, c, d, e, f, det, ns, nt, s, t, g1, g2, acc;
        llcp_pkg::t_out r;
        p1[0] = x.point1_x; p1[1] = x.point1_y; p1[2] = x.point1_z;
        d1[0] = x.dir1_x;   d1[1] = x.dir1_y;   d1[2] = x.dir1_z;
        p2[0] = x.point2_x; p2[1] = x.point2_y; p2[2] = x.point2_z;
        d2[0] = x.dir2_x;   d2[1] = x.dir2_y;   d2[2] = x.dir2_z;
        a = 0; b = 0; c = 0; d = 0; e = 0; f = 0;
        for (int i = 0; i < 3; i++) begin
            u = p1[i] - p2[i];
            a += d1[i] * d1[i];
            b -= d1[i] * d2[i];
            c += d2[i] * d2[i];
            d += d1[i] * u;
            e -= d2[i] * u;
            f += u * u;
        end
        det = a * c - b * b;
        if (det < 0) det = -det;
        r = '0;
        if (a == 0) begin
            r.dist_squared = llcp_pkg::LLCP_DIST_MAX;
            r.status = llcp_pkg::LLCP_ST_ZERO_DIR;
        end else if (det == 0) begin
            s = clamp_param(((-d) <<< 16) / a);
            acc = d * s + (f <<< 16);
            r.param_first = s[llcp_pkg::LLCP_PW-1:0];
            r.dist_squared = clamp_dist(acc, 16);
            r.status = llcp_pkg::LLCP_ST_PARALLEL;
        end else begin
            ns = b * e - c * d;
            nt = b * d - a * e;
            s = clamp_param((ns <<< 16) / det);
            t = clamp_param((nt <<< 16) / det);
            g1 = a * s + b * t + (d <<< 17);
            g2 = b * s + c * t + (e <<< 17);
            acc = s * g1 + t * g2 + (f <<< 32);
            r.param_first = s[llcp_pkg::LLCP_PW-1:0];
            r.param_second = t[llcp_pkg::LLCP_PW-1:0];
            r.dist_squared = clamp_dist(acc, 32);
            r.status = llcp_pkg::LLCP_ST_GENERAL;
        end
        return r;
    endfunction

    function automatic logic signed [15:0] rand_coord(int mag);
        logic [31:0] v;
        v = $urandom;
        case (mag)
            0: return $signed(v[15:0]);
            1: return $signed({{8{v[7]}}, v[7:0]});
            default: return $signed({{12{v[3]}}, v[3:0]});
        endcase
    endfunction

    function automatic llcp_pkg::t_in random_lines();
        llcp_pkg::t_in x;
        int mag;
        int k;
        mag = $urandom_range(0, 2);
        x.point1_x = rand_coord(mag); x.point1_y = rand_coord(mag); x.point1_z = rand_coord(mag);
        x.point2_x = rand_coord(mag); x.point2_y = rand_coord(mag); x.point2_z = rand_coord(mag);
        x.dir1_x = rand_coord(mag);   x.dir1_y = rand_coord(mag);   x.dir1_z = rand_coord(mag);
        x.dir2_x = rand_coord(mag);   x.dir2_y = rand_coord(mag);   x.dir2_z = rand_coord(mag);
        case ($urandom_range(0, 9))
            0: begin
                x.dir1_x = '0; x.dir1_y = '0; x.dir1_z = '0;
            end
            1, 2: begin
                // Second direction is a small multiple of the first.
                k = int'($urandom_range(0, 6)) - 3;
                if (k == 0) k = 1;
                x.dir1_x = rand_coord(2); x.dir1_y = rand_coord(2); x.dir1_z = rand_coord(2);
                x.dir2_x = 16'(x.dir1_x * k);
                x.dir2_y = 16'(x.dir1_y * k);
                x.dir2_z = 16'(x.dir1_z * k);
            end
            default: ;
        endcase
        return x;
    endfunction

    function automatic llcp_pkg::t_in make_lines(logic [15:0] p1, logic [15:0] d1,
                                                 logic [15:0] p2, logic [15:0] d2);
        llcp_pkg::t_in x;
        x.point1_x = p1; x.point1_y = p1; x.point1_z = p1;
        x.dir1_x = d1;   x.dir1_y = d1;   x.dir1_z = d1;
        x.point2_x = p2; x.point2_y = p2; x.point2_z = p2;
        x.dir2_x = d2;   x.dir2_y = d2;   x.dir2_z = d2;
        return x;
    endfunction

    // Stimulus: directed corner cases, then random streams, then drain.
    initial begin
        llcp_pkg::t_in x;
        pending_lines.push_back(make_lines(16'h0000, 16'h0000, 16'h0000, 16'h0000));
        pending_lines.push_back(make_lines(16'h7FFF, 16'h0000, 16'h8000, 16'h7FFF));
        pending_lines.push_back(make_lines(16'h7FFF, 16'h7FFF, 16'h8000, 16'h7FFF));
        pending_lines.push_back(make_lines(16'h7FFF, 16'h8000, 16'h8000, 16'h8000));
        pending_lines.push_back(make_lines(16'h8000, 16'h8000, 16'h7FFF, 16'h7FFF));
        pending_lines.push_back(make_lines(16'hFFFF, 16'h0001, 16'h0001, 16'hFFFF));
        pending_lines.push_back(make_lines(16'h0100, 16'h0100, 16'h0100, 16'h0100));
        pending_lines.push_back(make_lines(16'h8000, 16'h0001, 16'h7FFF, 16'h0000));
        // Perpendicular axes, skew lines.
        x = '0; x.dir1_x = 16'h0100; x.dir2_y = 16'h0100; x.point2_z = 16'h0200;
        pending_lines.push_back(x);
        x = '0; x.dir1_x = 16'h7FFF; x.dir2_y = 16'h8000;
        x.point1_z = 16'h7FFF; x.point2_z = 16'h8000;
        pending_lines.push_back(x);
        // Tiny direction, far points: parameters saturate.
        x = '0; x.dir1_x = 16'h0001; x.dir2_y = 16'h0001;
        x.point1_x = 16'h8000; x.point2_x = 16'h7FFF; x.point2_y = 16'h7FFF;
        pending_lines.push_back(x);
        x = '0; x.dir1_x = 16'h0001; x.dir2_x = 16'hFFFF; x.point1_y = 16'h7FFF;
        x.point2_x = 16'h8000;
        pending_lines.push_back(x);
        // Zero first direction with the rest at extremes.
        x = make_lines(16'h7FFF, 16'h0000, 16'h8000, 16'h7FFF);
        x.dir2_y = 16'h8000;
        pending_lines.push_back(x);
        // Zero second direction only.
        x = make_lines(16'h1234, 16'h00F0, 16'hEDCB, 16'h0000);
        pending_lines.push_back(x);
        for (int n = 0; n < 650; n++) pending_lines.push_back(random_lines());

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (pending_lines.size() != 0 || i_valid || expected_points.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (error_count == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

    // Sender: bursts of transactions separated by random gaps.
    always @(negedge i_clk) begin
        if (i_rst_n) begin
            if (i_valid && !input_taken) begin
                // Hold the stalled transaction unchanged.
            end else if (burst_left > 0 && pending_lines.size() != 0) begin
                i_data <= pending_lines.pop_front();
                i_valid <= 1'b1;
                burst_left--;
            end else if (gap_left > 0) begin
                i_valid <= 1'b0;
                gap_left--;
            end else begin
                i_valid <= 1'b0;
                burst_left = $urandom_range(1, 40);
                gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 8);
            end
        end
    end

    // Receiver: stall phases of varying density.
    always @(negedge i_clk) begin
        if (stall_phase_left == 0) begin
            stall_mode = $urandom_range(0, 3);
            stall_phase_left = $urandom_range(5, 80);
        end else begin
            stall_phase_left--;
        end
        case (stall_mode)
            0: i_stall <= 1'b0;
            1: i_stall <= ($urandom_range(0, 3) == 0);
            2: i_stall <= ($urandom_range(0, 1) == 0);
            default: i_stall <= ($urandom_range(0, 9) != 0);
        endcase
    end

    // Accepted input transactions feed the predictor; results are checked in order.
    always @(posedge i_clk) begin
        llcp_pkg::t_out want;
        bit moved;
        moved = 1'b0;
        input_taken = 1'b0;
        if (i_rst_n && i_valid && !o_stall) begin
            expected_points.push_back(closest_points(i_data));
            input_taken = 1'b1;
            moved = 1'b1;
        end
        if (i_rst_n && o_valid && !i_stall) begin
            moved = 1'b1;
            if (expected_points.size() == 0) begin
                $display("%0t: unexpected result %h", $time, o_data);
                error_count++;
            end else begin
                want = expected_points.pop_front();
                if (o_data.param_first !== want.param_first) begin
                    $display("%0t: param_first expected %h actual %h",
                             $time, want.param_first, o_data.param_first);
                    error_count++;
                end
                if (o_data.param_second !== want.param_second) begin
                    $display("%0t: param_second expected %h actual %h",
                             $time, want.param_second, o_data.param_second);
                    error_count++;
                end
                if (o_data.dist_squared !== want.dist_squared) begin
                    $display("%0t: dist_squared expected %h actual %h",
                             $time, want.dist_squared, o_data.dist_squared);
                    error_count++;
                end
                if (o_data.status !== want.status) begin
                    $display("%0t: status expected %h actual %h",
                             $time, want.status, o_data.status);
                    error_count++;
                end
            end
        end
        // Watchdog on cycles without any transaction.
        if (!i_rst_n || moved) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("TB_ERROR");
                $finish;
            end
        end
    end

endmodule

/* filelist.f */
rtl/llcp_pkg.sv
rtl/llcp_mul.sv
rtl/llcp_div.sv
rtl/llcp_front.sv
rtl/llcp_queue.sv
rtl/llcp_back.sv
rtl/line_line_closest_points_top.sv
tb/sv/tb_top.sv
